// ----- rtl/pet_pkg.sv -----
// Shared types and constants for the polynomial extrapolation tableau.
package pet_pkg;

  // Payload of one input transaction.
  typedef struct packed {
    logic [2:0]  column;
    logic [63:0] step_squared;
    logic [3:0]  var_index;
    logic [63:0] estimate;
  } pet_in_t;

  // Payload of one output transaction.
  typedef struct packed {
    logic [63:0] extrapolated;
    logic [63:0] error_estimate;
  } pet_out_t;

  // Operations of the shared floating-point unit.
  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_RCP
  } fpu_op_e;

  // Request into the floating-point unit.
  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  // Response from the floating-point unit.
  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

  // Floating-point unit sequencer states.
  typedef enum logic [2:0] {
    FS_IDLE,
    FS_ALIGN,
    FS_MUL,
    FS_DIV,
    FS_NORM,
    FS_ROUND,
    FS_DONE
  } fpu_state_e;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_OP,
    S_WAIT,
    S_LAST,
    S_OUT
  } pet_state_e;

  // Arithmetic steps of one backward pass through a column.
  typedef enum logic [2:0] {
    P_DIFF,
    P_RECIP,
    P_G1,
    P_G2,
    P_T,
    P_CORR,
    P_CARRY,
    P_TOTAL
  } pet_step_e;

  // Default quiet NaN produced by invalid operations.
  localparam logic [63:0] DP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  // Exponent field of infinities and NaNs.
  localparam logic [10:0] DP_EXP_MAX = 11'h7FF;

endpackage

// ----- rtl/polynomial_extrapolation_tableau.sv -----
// Top level of the polynomial extrapolation tableau with its two memories.
//
//  Channel | Valid      | Stall       | Payload
//  --------+------------+-------------+----------------------
//  input   | in_valid_i | in_stall_o  | in_data_i  (pet_in_t)
//  output  | out_valid_o| out_stall_i | out_data_o (pet_out_t)
//
// One item is worked on at a time. Column zero and an out-of-range variable pass from
// acceptance through the start and output states only. A higher column k runs k backward
// steps: each backward step runs eight operations on the one shared floating-point unit,
// and its reciprocal runs in the two-bit-per-cycle divider. Infinite and NaN operands go
// straight to the done state of an operation; deep cancellation and subnormals add
// normalization shifts.
// Reset clears all control state; the memories need no clearing pass.
// One result waiting on a stalled output lets the next item be taken and worked; that
// item then waits in the output state with the input stalled.
module polynomial_extrapolation_tableau import pet_pkg::*; #(
  parameter int MAX_COLUMNS = 8,
  parameter int NUM_VARS    = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pet_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pet_out_t out_data_o
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int DEPTH  = NUM_VARS * MAX_COLUMNS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pet_state_e state_q, state_d;
  pet_step_e  step_q, step_d;
  logic [COL_W-1:0] col_q, col_d, k_q, k_d;
  logic [3:0]       var_q, var_d;
  logic             var_ok_q, var_ok_d;
  logic [63:0] xest_q, xest_d, est_q, est_d;
  logic [63:0] total_q, total_d, corr_q, corr_d, carry_q, carry_d;
  logic [63:0] r_q, r_d, g1_q, g1_d, g2_q, g2_d, t_q, t_d;
  logic        out_valid_q, out_valid_d;
  pet_out_t    out_data_q, out_data_d;

  // Memory ports.
  logic [63:0]       st_mem [MAX_COLUMNS];
  logic [63:0]       dt_mem [DEPTH];
  logic              st_we, st_re, dt_we, dt_re;
  logic [COL_W-1:0]  st_waddr, st_raddr;
  logic [ADDR_W-1:0] dt_waddr, dt_raddr;
  logic [63:0]       dt_wdata, xp_q, prev_q;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  logic in_fire, out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  pet_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  // Next state of the item sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_START;
      S_START: state_d = (!var_ok_q || (col_q == '0)) ? S_OUT : S_READ;
      S_READ:  state_d = S_OP;
      S_OP:    state_d = S_WAIT;
      S_WAIT: begin
        if (fpu_rsp.done) begin
          if (step_q != P_TOTAL) begin
            state_d = S_OP;
          end else if ((k_q + COL_W'(1)) == col_q) begin
            state_d = S_LAST;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_LAST:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory and arithmetic unit controls.
  always_comb begin
    st_we         = (state_q == S_START) && var_ok_q;
    st_waddr      = col_q;
    st_re         = (state_q == S_READ);
    st_raddr      = col_q - k_q - COL_W'(1);
    dt_re         = (state_q == S_READ);
    dt_raddr      = ADDR_W'(32'(var_q) * 32'(MAX_COLUMNS) + 32'(k_q));
    dt_we         = 1'b0;
    dt_waddr      = ADDR_W'(32'(var_q) * 32'(MAX_COLUMNS) + 32'(k_q));
    dt_wdata      = corr_q;
    fpu_req.start = (state_q == S_OP);
    fpu_req.op    = FOP_MUL;
    fpu_req.a     = xest_q;
    fpu_req.b     = r_q;
    unique case (state_q)
      S_START: begin
        dt_we    = var_ok_q && (col_q == '0);
        dt_wdata = est_q;
      end
      S_OP:   dt_we = (step_q == P_T);
      S_LAST: begin
        dt_we    = 1'b1;
        dt_waddr = ADDR_W'(32'(var_q) * 32'(MAX_COLUMNS) + 32'(col_q));
      end
      default: begin
      end
    endcase
    unique case (step_q)
      P_DIFF: begin
        fpu_req.op = FOP_SUB;
        fpu_req.a  = xp_q;
        fpu_req.b  = xest_q;
      end
      P_RECIP: begin
        fpu_req.op = FOP_RCP;
        fpu_req.a  = r_q;
      end
      P_G1: begin
        fpu_req.a = xest_q;
      end
      P_G2: begin
        fpu_req.a = xp_q;
      end
      P_T: begin
        fpu_req.op = FOP_SUB;
        fpu_req.a  = carry_q;
        fpu_req.b  = prev_q;
      end
      P_CORR: begin
        fpu_req.a = g1_q;
        fpu_req.b = t_q;
      end
      P_CARRY: begin
        fpu_req.a = g2_q;
        fpu_req.b = t_q;
      end
      default: begin
        fpu_req.op = FOP_ADD;
        fpu_req.a  = total_q;
        fpu_req.b  = corr_q;
      end
    endcase
  end

  // Item registers and results of the arithmetic steps.
  always_comb begin
    step_d      = step_q;
    col_d       = col_q;
    k_d         = k_q;
    var_d       = var_q;
    var_ok_d    = var_ok_q;
    xest_d      = xest_q;
    est_d       = est_q;
    total_d     = total_q;
    corr_d      = corr_q;
    carry_d     = carry_q;
    r_d         = r_q;
    g1_d        = g1_q;
    g2_d        = g2_q;
    t_d         = t_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (32'(in_data_i.column) > MAX_COLUMNS - 1) begin
            col_d = COL_W'(MAX_COLUMNS - 1);
          end else begin
            col_d = COL_W'(in_data_i.column);
          end
          var_d    = in_data_i.var_index;
          var_ok_d = (32'(in_data_i.var_index) < NUM_VARS);
          xest_d   = in_data_i.step_squared;
          est_d    = in_data_i.estimate;
          total_d  = in_data_i.estimate;
          corr_d   = in_data_i.estimate;
          carry_d  = in_data_i.estimate;
          k_d      = '0;
          step_d   = P_DIFF;
        end
      end
      S_WAIT: begin
        if (fpu_rsp.done) begin
          case (step_q) inside
            P_DIFF, P_RECIP: r_d = fpu_rsp.result;
            P_G1:            g1_d = fpu_rsp.result;
            P_G2:            g2_d = fpu_rsp.result;
            P_T:             t_d = fpu_rsp.result;
            P_CORR:          corr_d = fpu_rsp.result;
            P_CARRY:         carry_d = fpu_rsp.result;
            default:         total_d = fpu_rsp.result;
          endcase
          if (step_q == P_TOTAL) begin
            step_d = P_DIFF;
            k_d    = k_q + COL_W'(1);
          end else begin
            step_d = pet_step_e'(step_q + 3'd1);
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.extrapolated    = total_q;
          out_data_d.error_estimate  = corr_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= P_DIFF;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    var_q      <= var_d;
    var_ok_q   <= var_ok_d;
    xest_q     <= xest_d;
    est_q      <= est_d;
    total_q    <= total_d;
    corr_q     <= corr_d;
    carry_q    <= carry_d;
    r_q        <= r_d;
    g1_q       <= g1_d;
    g2_q       <= g2_d;
    t_q        <= t_d;
    out_data_q <= out_data_d;
  end

  // Squared substep memory, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= xest_q;
    end
    if (st_re) begin
      xp_q <= st_mem[st_raddr];
    end
  end

  // Difference memory, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (dt_we) begin
      dt_mem[dt_waddr] <= dt_wdata;
    end
    if (dt_re) begin
      prev_q <= dt_mem[dt_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The arithmetic unit never gets a second start on the heels of the first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_req.start |=> !fpu_req.start)
    else $error("arithmetic unit restarted while busy");

  // Backward steps stay below the item's column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OP) |-> (k_q < col_q))
    else $error("backward step index reached the column");

  // Difference writes stay inside the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dt_we |-> (32'(dt_waddr) < DEPTH))
    else $error("difference write out of range");

  // A new result only appears from the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside the output state");

endmodule

// ----- rtl/pet_fpu.sv -----
// Multi-cycle double-precision add, subtract, multiply and reciprocal unit.
module pet_fpu import pet_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fpu_req_t req_i,
  output fpu_rsp_t rsp_o
);

  fpu_state_e state_q, state_d;

  logic               sign_q, sign_d;
  logic signed [15:0] exp_q, exp_d;
  logic [127:0]       man_q, man_d;
  logic [52:0]        siga_q, siga_d, sigb_q, sigb_d;
  logic [10:0]        ea_q, ea_d, eb_q, eb_d;
  logic               sa_q, sa_d, sb_q, sb_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [53:0]        pp_q, pp_d;
  logic [52:0]        rem_q, rem_d;
  logic [63:0]        res_q, res_d;

  // Operand decode of the incoming request.
  logic [10:0] in_ea, in_eb, in_eaeff, in_ebeff;
  logic [51:0] in_fa, in_fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbeff, special;
  logic [63:0] spec_res;

  always_comb begin
    in_ea    = req_i.a[62:52];
    in_eb    = req_i.b[62:52];
    in_fa    = req_i.a[51:0];
    in_fb    = req_i.b[51:0];
    in_eaeff = (in_ea == 11'd0) ? 11'd1 : in_ea;
    in_ebeff = (in_eb == 11'd0) ? 11'd1 : in_eb;
    a_nan    = (in_ea == DP_EXP_MAX) && (in_fa != 52'd0);
    b_nan    = (in_eb == DP_EXP_MAX) && (in_fb != 52'd0);
    a_inf    = (in_ea == DP_EXP_MAX) && (in_fa == 52'd0);
    b_inf    = (in_eb == DP_EXP_MAX) && (in_fb == 52'd0);
    a_zero   = (in_ea == 11'd0) && (in_fa == 52'd0);
    b_zero   = (in_eb == 11'd0) && (in_fb == 52'd0);
    sbeff    = req_i.b[63] ^ (req_i.op == FOP_SUB);
    special  = 1'b0;
    spec_res = 64'd0;
    case (req_i.op)
      FOP_ADD, FOP_SUB: begin
        special = a_nan || b_nan || a_inf || b_inf;
        if (a_nan) begin
          spec_res = {req_i.a[63:52], 1'b1, req_i.a[50:0]};
        end else if (b_nan) begin
          spec_res = {req_i.b[63:52], 1'b1, req_i.b[50:0]};
        end else if (a_inf && b_inf && (req_i.a[63] != sbeff)) begin
          spec_res = DP_DEFAULT_NAN;
        end else if (a_inf) begin
          spec_res = req_i.a;
        end else begin
          spec_res = {sbeff, req_i.b[62:0]};
        end
      end
      FOP_MUL: begin
        special = a_nan || b_nan || a_inf || b_inf;
        if (a_nan) begin
          spec_res = {req_i.a[63:52], 1'b1, req_i.a[50:0]};
        end else if (b_nan) begin
          spec_res = {req_i.b[63:52], 1'b1, req_i.b[50:0]};
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
          spec_res = DP_DEFAULT_NAN;
        end else begin
          spec_res = {req_i.a[63] ^ req_i.b[63], DP_EXP_MAX, 52'd0};
        end
      end
      default: begin
        special = a_nan || a_inf || a_zero;
        if (a_nan) begin
          spec_res = {req_i.a[63:52], 1'b1, req_i.a[50:0]};
        end else if (a_inf) begin
          spec_res = {req_i.a[63], 63'd0};
        end else begin
          spec_res = {req_i.a[63], DP_EXP_MAX, 52'd0};
        end
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: begin
        if (req_i.start) begin
          if (special) begin
            state_d = FS_DONE;
          end else begin
            unique case (req_i.op)
              FOP_ADD, FOP_SUB: state_d = FS_ALIGN;
              FOP_MUL:          state_d = FS_MUL;
              default:          state_d = FS_DIV;
            endcase
          end
        end
      end
      FS_ALIGN: state_d = FS_NORM;
      FS_MUL:   if (cnt_q == 7'd4) state_d = FS_NORM;
      FS_DIV:   if (cnt_q == 7'd1) state_d = FS_NORM;
      FS_NORM: begin
        if (man_q == 128'd0) begin
          state_d = FS_DONE;
        end else if (man_q[127]) begin
          state_d = FS_ROUND;
        end
      end
      FS_ROUND: state_d = FS_DONE;
      FS_DONE:  state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  // Datapath of every state.
  logic [10:0]        d_exp;
  logic [6:0]         d_sh;
  logic [127:0]       full_b, mask_b, aa, bb, sum;
  logic               sum_sign;
  logic [26:0]        mul_x, mul_y;
  logic [6:0]         pp_sh;
  logic               nb1, nb2, q1, q2;
  logic [53:0]        r1, r2, dvs;
  logic [52:0]        r1b, r2b;
  logic [63:0]        m64, m64s, lost_mask;
  logic signed [15:0] biased, shr;
  logic [10:0]        ef;
  logic               rnd_inc;

  always_comb begin
    sign_d    = sign_q;
    exp_d     = exp_q;
    man_d     = man_q;
    siga_d    = siga_q;
    sigb_d    = sigb_q;
    ea_d      = ea_q;
    eb_d      = eb_q;
    sa_d      = sa_q;
    sb_d      = sb_q;
    cnt_d     = cnt_q;
    pp_d      = pp_q;
    rem_d     = rem_q;
    res_d     = res_q;
    d_exp     = ea_q - eb_q;
    d_sh      = (d_exp > 11'd127) ? 7'd127 : d_exp[6:0];
    full_b    = {11'd0, sigb_q, 64'd0};
    mask_b    = (128'd1 << d_sh) - 128'd1;
    bb        = (full_b >> d_sh) | {127'd0, |(full_b & mask_b)};
    aa        = {11'd0, siga_q, 64'd0};
    sum       = 128'd0;
    sum_sign  = sa_q;
    mul_x     = 27'd0;
    mul_y     = 27'd0;
    pp_sh     = 7'd0;
    dvs       = {1'b0, sigb_q};
    nb1       = (cnt_q == 7'd116);
    r1        = {rem_q, nb1};
    q1        = (r1 >= dvs);
    r1b       = q1 ? 53'(r1 - dvs) : r1[52:0];
    nb2       = ((cnt_q - 7'd1) == 7'd116);
    r2        = {r1b, nb2};
    q2        = (r2 >= dvs);
    r2b       = q2 ? 53'(r2 - dvs) : r2[52:0];
    m64       = {man_q[127:65], man_q[64] | (|man_q[63:0])};
    biased    = exp_q + 16'sd1150;
    shr       = 16'sd1 - biased;
    lost_mask = 64'd0;
    m64s      = m64;
    ef        = 11'd0;
    rnd_inc   = 1'b0;
    case (state_q)
      FS_IDLE: begin
        if (req_i.start) begin
          res_d = spec_res;
          unique case (req_i.op)
            FOP_ADD, FOP_SUB: begin
              if (in_eaeff >= in_ebeff) begin
                siga_d = {in_ea != 11'd0, in_fa};
                sigb_d = {in_eb != 11'd0, in_fb};
                ea_d   = in_eaeff;
                eb_d   = in_ebeff;
                sa_d   = req_i.a[63];
                sb_d   = sbeff;
              end else begin
                siga_d = {in_eb != 11'd0, in_fb};
                sigb_d = {in_ea != 11'd0, in_fa};
                ea_d   = in_ebeff;
                eb_d   = in_eaeff;
                sa_d   = sbeff;
                sb_d   = req_i.a[63];
              end
            end
            FOP_MUL: begin
              siga_d = {in_ea != 11'd0, in_fa};
              sigb_d = {in_eb != 11'd0, in_fb};
              sign_d = req_i.a[63] ^ req_i.b[63];
              exp_d  = $signed({5'd0, in_eaeff}) + $signed({5'd0, in_ebeff}) - 16'sd2150;
              man_d  = 128'd0;
              cnt_d  = 7'd0;
            end
            default: begin
              sigb_d = {in_ea != 11'd0, in_fa};
              sign_d = req_i.a[63];
              exp_d  = 16'sd959 - $signed({5'd0, in_eaeff});
              man_d  = 128'd0;
              rem_d  = 53'd0;
              cnt_d  = 7'd117;
            end
          endcase
        end
      end
      // Alignment and signed-magnitude add of the two significands.
      FS_ALIGN: begin
        if (sa_q == sb_q) begin
          sum = aa + bb;
        end else if (aa >= bb) begin
          sum = aa - bb;
        end else begin
          sum      = bb - aa;
          sum_sign = sb_q;
        end
        if (sum == 128'd0) begin
          sum_sign = sa_q & sb_q;
        end
        man_d  = sum;
        sign_d = sum_sign;
        exp_d  = $signed({5'd0, ea_q}) - 16'sd1139;
      end
      // One 27x27 partial product per cycle, registered before it is accumulated.
      FS_MUL: begin
        case (cnt_q[1:0])
          2'd0: begin
            mul_x = siga_q[26:0];
            mul_y = sigb_q[26:0];
          end
          2'd1: begin
            mul_x = siga_q[26:0];
            mul_y = {1'b0, sigb_q[52:27]};
          end
          2'd2: begin
            mul_x = {1'b0, siga_q[52:27]};
            mul_y = sigb_q[26:0];
          end
          default: begin
            mul_x = {1'b0, siga_q[52:27]};
            mul_y = {1'b0, sigb_q[52:27]};
          end
        endcase
        pp_d = mul_x * mul_y;
        case (cnt_q)
          7'd2, 7'd3: pp_sh = 7'd27;
          7'd4:       pp_sh = 7'd54;
          default:    pp_sh = 7'd0;
        endcase
        if (cnt_q != 7'd0) begin
          man_d = man_q + ({74'd0, pp_q} << pp_sh);
        end
        cnt_d = cnt_q + 7'd1;
      end
      // Two restoring division steps per cycle for the reciprocal.
      FS_DIV: begin
        rem_d = r2b;
        man_d = {man_q[125:0], q1, q2};
        if (cnt_q == 7'd1) begin
          man_d[0] = q2 | (r2b != 53'd0);
        end
        cnt_d = cnt_q - 7'd2;
      end
      // Left normalization, eight places or one per cycle.
      FS_NORM: begin
        if (man_q == 128'd0) begin
          res_d = {sign_q, 63'd0};
        end else if (!man_q[127]) begin
          if (man_q[127:120] == 8'd0) begin
            man_d = man_q << 8;
            exp_d = exp_q - 16'sd8;
          end else begin
            man_d = man_q << 1;
            exp_d = exp_q - 16'sd1;
          end
        end
      end
      // Overflow to infinity, subnormal shift, round to nearest even and packing.
      FS_ROUND: begin
        if (biased >= 16'sd2047) begin
          res_d = {sign_q, DP_EXP_MAX, 52'd0};
        end else begin
          if (biased < 16'sd1) begin
            if (shr >= 16'sd64) begin
              m64s = {63'd0, |m64};
            end else begin
              lost_mask = (64'd1 << shr[5:0]) - 64'd1;
              m64s      = (m64 >> shr[5:0]) | {63'd0, |(m64 & lost_mask)};
            end
            ef = 11'd0;
          end else begin
            ef = biased[10:0];
          end
          rnd_inc = m64s[10] & ((|m64s[9:0]) | m64s[11]);
          res_d   = {sign_q, ef, m64s[62:11]} + {63'd0, rnd_inc};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= 7'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    exp_q  <= exp_d;
    man_q  <= man_d;
    siga_q <= siga_d;
    sigb_q <= sigb_d;
    ea_q   <= ea_d;
    eb_q   <= eb_d;
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    pp_q   <= pp_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign rsp_o.done   = (state_q == FS_DONE);
  assign rsp_o.result = res_q;

endmodule

// ----- tb/polynomial_extrapolation_tableau_test.sv -----
// Testbench for the polynomial extrapolation tableau: random column sequences with scoreboard.
`timescale 1ns / 100ps

module polynomial_extrapolation_tableau_test;
  import pet_pkg::*;

  localparam int MAX_COLS = 8;
  localparam int VARS     = 10;
  localparam int ITEM_GOAL = 800;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  pet_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  pet_out_t out_data_o;

  polynomial_extrapolation_tableau #(
    .MAX_COLUMNS(MAX_COLS),
    .NUM_VARS(VARS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  // Predicts the tableau and checks the results in order.
  class tableau_scoreboard;
    real      steps[MAX_COLS];
    real      diffs[VARS][MAX_COLS];
    pet_out_t expected_q[$];
    int       mismatches;
    int       results_seen;

    function new();
      mismatches = 0;
      results_seen = 0;
      for (int c = 0; c < MAX_COLS; c++) begin
        steps[c] = 0.0;
        for (int v = 0; v < VARS; v++) diffs[v][c] = 0.0;
      end
    endfunction

    // A zero divisor gives an infinity that carries the zero's sign.
    function real reciprocal(real den);
      logic [63:0] b;
      b = $realtobits(den);
      if (den == 0.0) return $bitstoreal({b[63], 11'h7FF, 52'h0});
      return 1.0 / den;
    endfunction

    function bit is_nan(logic [63:0] b);
      return b[62:52] == 11'h7FF && b[51:0] != 52'h0;
    endfunction

    // Any NaN is accepted for a NaN, since payloads are not modelled.
    function bit same_double(logic [63:0] a, logic [63:0] b);
      return a == b || (is_nan(a) && is_nan(b));
    endfunction

    // Runs one accepted transaction through the tableau and queues the result.
    function void note_input(pet_in_t item);
      int       col;
      int       v;
      real      xest, est, total, corr, carry, xp, r, g1, g2, prev, t;
      pet_out_t res;
      col = int'(item.column);
      v = int'(item.var_index);
      xest = $bitstoreal(item.step_squared);
      est = $bitstoreal(item.estimate);
      if (col > MAX_COLS - 1) col = MAX_COLS - 1;
      if (v >= VARS) begin
        res.extrapolated = item.estimate;
        res.error_estimate = item.estimate;
        expected_q = {expected_q, res};
        return;
      end
      steps[col] = xest;
      total = est;
      corr = est;
      if (col == 0) begin
        diffs[v][0] = est;
      end else begin
        carry = est;
        for (int k = 0; k < col; k++) begin
          xp = steps[col - k - 1];
          r = reciprocal(xp - xest);
          g1 = xest * r;
          g2 = xp * r;
          prev = diffs[v][k];
          diffs[v][k] = corr;
          t = carry - prev;
          corr = g1 * t;
          carry = g2 * t;
          total = total + corr;
        end
        diffs[v][col] = corr;
      end
      res.extrapolated = $realtobits(total);
      res.error_estimate = $realtobits(corr);
      expected_q = {expected_q, res};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
      mismatches++;
    endtask

    // Compares one accepted output transaction against the oldest prediction.
    task check_result(pet_out_t got);
      pet_out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected result", got.extrapolated, 64'h0);
        return;
      end
      want = expected_q.pop_front();
      if (!same_double(got.extrapolated, want.extrapolated))
        report("extrapolated", got.extrapolated, want.extrapolated);
      if (!same_double(got.error_estimate, want.error_estimate))
        report("error_estimate", got.error_estimate, want.error_estimate);
    endtask
  endclass

  tableau_scoreboard board;
  int  items_sent;
  int  deepest_column;
  int  last_column[VARS];
  bit  quiet;
  bit  hold_req;
  bit  timed_out;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Output check on every accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // Receiver stall pattern: bursts, one long hold, and none at the end.
  initial begin
    int n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end else begin
        n = $urandom_range(1, 12);
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat (n) @(negedge clk_i);
      end
    end
  end

  // Offers one transaction and waits until it is taken.
  task send_item(logic [2:0] col, logic [63:0] step_sq, logic [3:0] v, logic [63:0] est);
    pet_in_t item;
    item.column = col;
    item.step_squared = step_sq;
    item.var_index = v;
    item.estimate = est;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(item);
    items_sent++;
    if (v < VARS) begin
      if (int'(col) > last_column[v]) last_column[v] = int'(col);
      if (int'(col) > deepest_column) deepest_column = int'(col);
    end
    @(negedge clk_i);
  endtask

  function logic [63:0] random_bits();
    return {$urandom(), $urandom()};
  endfunction

  // A well-formed run of columns 0..top for one variable with realistic values.
  task run_sequence(int v, int top, bit equal_steps);
    real h, base, est;
    h = $urandom_range(1, 2000) / 1000.0;
    base = ($urandom_range(0, 20000) - 10000.0) / 97.0;
    for (int c = 0; c <= top; c++) begin
      real sub;
      sub = (equal_steps && c == top && c > 0) ? h / (2.0 * c) : h / (2.0 * (c + 1));
      est = base + sub * sub * ($urandom_range(0, 1000) / 333.0) + $urandom_range(0, 9) * 1e-9;
      send_item(c[2:0], $realtobits(sub * sub), v[3:0], $realtobits(est));
    end
  endtask

  // Stimulus: directed cases, then random sequences and noise.
  initial begin
    int v, top, col;
    board = new();
    items_sent = 0;
    deepest_column = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    for (int i = 0; i < VARS; i++) last_column[i] = -1;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Out-of-range variables, field extremes and special values.
    send_item(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(3'd0, 64'h0, 4'd10, 64'h0);
    send_item(3'd0, 64'h0, 4'd0, 64'h8000_0000_0000_0000);
    send_item(3'd0, 64'h7FF0_0000_0000_0000, 4'd1, 64'h7FF0_0000_0000_0000);
    send_item(3'd1, 64'h3FF0_0000_0000_0000, 4'd1, 64'h0000_0000_0000_0001);
    // Full-depth tableau on the last variable.
    run_sequence(VARS - 1, MAX_COLS - 1, 1'b0);
    // Equal step sizes give an infinite reciprocal.
    send_item(3'd0, 64'h3FD0_0000_0000_0000, 4'd2, 64'h4000_0000_0000_0000);
    send_item(3'd1, 64'h3FD0_0000_0000_0000, 4'd2, 64'h4008_0000_0000_0000);
    run_sequence(3, 3, 1'b1);

    // Long output hold while column-zero items keep coming.
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_item(3'd0, random_bits(), 4'($urandom_range(0, VARS - 1)), random_bits());
    wait (!hold_req);

    // Random part: mostly well-formed sequences, some noise.
    while (items_sent < ITEM_GOAL) begin
      if (items_sent > ITEM_GOAL - 120) quiet = 1'b1;
      v = $urandom_range(0, VARS - 1);
      case ($urandom_range(0, 9))
        0: begin
          send_item(3'($urandom), random_bits(), 4'($urandom_range(VARS, 15)), random_bits());
        end
        1: begin
          col = (last_column[v] < 0) ? 0 : $urandom_range(0, last_column[v] + 1);
          if (col > MAX_COLS - 1) col = MAX_COLS - 1;
          send_item(col[2:0], random_bits(), v[3:0], random_bits());
        end
        default: begin
          top = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
          run_sequence(v, top, $urandom_range(0, 9) == 0);
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // Drain and settle.
    timed_out = 1'b1;
    for (int i = 0; i < 2_000_000; i++) begin
      if (board.expected_q.size() == 0) begin
        timed_out = 1'b0;
        break;
      end
      @(posedge clk_i);
    end
    if (timed_out) begin
      $display("TB_ERROR");
      $finish;
    end
    repeat (1200) @(posedge clk_i);

    $display("Covered %0d transactions and %0d results, columns up to %0d,",
             items_sent, board.results_seen, deepest_column);
    $display("with stalls on both sides and a long output hold; %0d mismatches.",
             board.mismatches);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
